/* rtl/depm_pkg.sv */
`default_nettype none
package depm_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int SECTOR_COUNT = 8;

	localparam int TS_W     = 32;
	localparam int TOL_W    = 16;
	localparam int PERIOD_W = 40;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd20;

	// x / 5 == (x * 0xCCCCCCCD) >> 34 for every 32-bit x
	localparam logic [TS_W-1:0] DIV5_MUL   = 32'hCCCC_CCCD;
	localparam int              DIV5_SHIFT = 34;

	typedef enum logic [1:0] {
		ACT_RISE = 2'd0,
		ACT_FALL = 2'd1,
		ACT_HALL = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		logic            tok;
		logic [TS_W-1:0] pmax;
		logic [TS_W-1:0] val;
	} link_t;

endpackage
`default_nettype wire

/* rtl/depm_if.sv */
`default_nettype none
interface depm_evt_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [depm_pkg::TS_W-1:0] timestamp;

	modport source (output valid, action, timestamp, input ready);
	modport sink (input valid, action, timestamp, output ready);
endinterface

interface depm_res_if;
	logic                          valid;
	logic                          ready;
	logic [depm_pkg::TS_W-1:0]     window_max;
	logic [depm_pkg::PERIOD_W-1:0] cycle_period;
	logic                          steady;
	logic [depm_pkg::TS_W-1:0]     hall_time;

	modport source (output valid, window_max, cycle_period, steady, hall_time, input ready);
	modport sink (input valid, window_max, cycle_period, steady, hall_time, output ready);
endinterface
`default_nettype wire

/* rtl/depm_cell.sv */
`default_nettype none
module depm_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift_en,
	input  wire depm_pkg::link_t link_in,
	output depm_pkg::link_t      link_out
);
	import depm_pkg::*;

	logic [TS_W-1:0] val_q;
	logic [TS_W-1:0] pmax_s;
	logic            tok_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			pmax_s <= '0;
			tok_s  <= 1'b0;
		end else begin
			if (shift_en) begin
				val_q <= link_in.val;
			end
			pmax_s <= (val_q > link_in.pmax) ? val_q : link_in.pmax;
			tok_s  <= link_in.tok;
		end
	end

	assign link_out.tok  = tok_s;
	assign link_out.pmax = pmax_s;
	assign link_out.val  = val_q;

endmodule
`default_nettype wire

/* rtl/disk_edge_period_monitor.sv */
`default_nettype none
// An accepted event beat launches a token down the cell chain; its result is loaded into the
// output register when the token leaves the last cell and that register is free. No new event is
// taken until then; the running maximum walks the cell chain one cell per cycle.
// A finished result waits in the output register while the next event is taken.
// Reset clears window, times, previous delta and steady flag; tolerance resets to 20.
module disk_edge_period_monitor (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	depm_evt_if.sink                        evt,
	depm_res_if.source                      res,
	input  wire logic                       cfg_we,
	input  wire logic [depm_pkg::TOL_W-1:0] cfg_wdata
);
	import depm_pkg::*;

	logic [TS_W-1:0]  rise_q, fall_q, hall_q, prev_q, grow_lim_q;
	logic [TOL_W-1:0] tol_q;
	logic             steady_q;
	logic             busy_q, start_q, hold_q, res_valid_q;
	logic [TS_W-1:0]  hold_max_q;
	logic [TS_W-1:0]     res_max_q;
	logic [PERIOD_W-1:0] res_period_q;
	logic                res_steady_q;
	logic [TS_W-1:0]     res_hall_q;

	logic            accept, is_photo, unsteady, res_free, last_tok, load;
	logic [TS_W-1:0] delta, gap, load_max;
	logic [2*TS_W-1:0] div_prod;
	action_t         act;

	link_t chain [WINDOW_DEPTH+1];

	assign act      = action_t'(evt.action);
	assign accept   = evt.valid && evt.ready;
	assign evt.ready = !busy_q;

	always_comb begin
		is_photo = 1'b0;
		delta    = evt.timestamp - rise_q;
		unique case (act)
			ACT_RISE: begin
				is_photo = 1'b1;
				delta    = evt.timestamp - fall_q;
			end
			ACT_FALL: begin
				is_photo = 1'b1;
				delta    = evt.timestamp - rise_q;
			end
			default: begin
				is_photo = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (delta > prev_q) begin
			gap      = delta - prev_q;
			unsteady = gap > grow_lim_q;
		end else begin
			gap      = prev_q - delta;
			unsteady = gap > {{(TS_W-TOL_W){1'b0}}, tol_q};
		end
	end

	assign div_prod = {{TS_W{1'b0}}, prev_q} * {{TS_W{1'b0}}, DIV5_MUL};

	assign chain[0].tok  = start_q;
	assign chain[0].pmax = '0;
	assign chain[0].val  = delta;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		depm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept && is_photo),
			.link_in  (chain[i]),
			.link_out (chain[i+1])
		);
	end

	assign last_tok = chain[WINDOW_DEPTH].tok;
	assign res_free = !res_valid_q || res.ready;
	assign load     = (last_tok || hold_q) && res_free;
	assign load_max = hold_q ? hold_max_q : chain[WINDOW_DEPTH].pmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q      <= '0;
			fall_q      <= '0;
			hall_q      <= '0;
			prev_q      <= '0;
			grow_lim_q  <= '0;
			steady_q    <= 1'b0;
			tol_q       <= TOL_RESET;
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			hold_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			grow_lim_q <= TS_W'(div_prod[2*TS_W-1:DIV5_SHIFT]);
			start_q    <= accept;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
				if (act == ACT_RISE) begin
					rise_q <= evt.timestamp;
				end
				if (act == ACT_FALL) begin
					fall_q <= evt.timestamp;
				end
				if (act == ACT_HALL) begin
					hall_q <= evt.timestamp;
				end
				if (is_photo) begin
					prev_q   <= delta;
					steady_q <= !unsteady;
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
				hold_q      <= 1'b0;
				busy_q      <= 1'b0;
			end else begin
				if (res.ready) begin
					res_valid_q <= 1'b0;
				end
				if (last_tok) begin
					hold_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last_tok && !hold_q) begin
			hold_max_q <= chain[WINDOW_DEPTH].pmax;
		end
		if (load) begin
			res_max_q    <= load_max;
			res_period_q <= PERIOD_W'(load_max) * PERIOD_W'(SECTOR_COUNT);
			res_steady_q <= steady_q;
			res_hall_q   <= hall_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.window_max   = res_max_q;
	assign res.cycle_period = res_period_q;
	assign res.steady       = res_steady_q;
	assign res.hall_time    = res_hall_q;

endmodule
`default_nettype wire
